@@ sv/set_assoc_lru_cache_model_defines.svh @@
// Assertion macros for the cache model RTL (included by slc_back).
// SLC_ASSERT checks on every clock edge outside reset.
// SLC_ASSERT_RST also checks on the edges where reset is applied.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH

`ifndef SYNTHESIS
`define SLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SLC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SLC_ASSERT(lbl, prop, msg)
`define SLC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ sv/slc_pkg.sv @@
package slc_pkg;

    // Field widths
    localparam int ADDR_W     = 64;
    localparam int CMD_W      = 2;
    localparam int TAG_W      = 62;
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Result word layout, lowest bit first, padded to whole bytes
    localparam int OUT_HIT_BIT   = 0;
    localparam int OUT_EVICT_BIT = 1;
    localparam int OUT_EXTRA_BIT = 2;
    localparam int OUT_HITS_LO   = 3;
    localparam int OUT_MISS_LO   = OUT_HITS_LO + CNT_W;
    localparam int OUT_EVICT_LO  = OUT_MISS_LO + CNT_W;
    localparam int OUT_USED_W    = OUT_EVICT_LO + CNT_W;
    localparam int OUT_W         = ((OUT_USED_W + 7) / 8) * 8;

    // Access kinds
    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    // Effective configuration, already clamped to legal values
    typedef struct packed {
        logic [2:0] set_bits;
        logic [5:0] block_bits;
        logic [3:0] ways;
    } t_cfg;

endpackage

@@ sv/set_assoc_lru_cache_model.sv @@
// Set-associative cache model with LRU replacement. Each input word is one access
// (tuser = command: load, store or modify; tdata = 64-bit byte address) and yields one
// result word with hit/eviction flags and the running hit, miss and eviction totals.
// A front end splits the address into set and tag and parks it in a two-entry queue,
// so accesses are taken every cycle until the queue fills. The lookup engine fetches
// the set row, compares tags and ages, and writes the row back, one access at a time,
// since a set row is fetched only after the previous access has written its row
// back; a result waiting in the output register stalls only the write-back. After
// reset the set memory is swept clear, one set per cycle through all 2^MAX_SET_BITS
// sets (64 by default), and no access is taken during the sweep. Configuration may be
// written only while the block is idle.
module set_assoc_lru_cache_model #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [slc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // access stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [slc_pkg::ADDR_W-1:0]        i_s_tdata,  // [63:0] address
    input  logic [slc_pkg::CMD_W-1:0]         i_s_tuser,  // [1:0] cmd
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] was_hit, [1] was_eviction, [2] extra_hit, [34:3] hit_total,
    // [66:35] miss_total, [98:67] eviction_total, [103:99] zero
    output logic [slc_pkg::OUT_W-1:0]         o_m_tdata
);

    localparam int ENTRY_W = MAX_SET_BITS + slc_pkg::TAG_W + 1;
    localparam logic [3:0] SB_CAP = 4'((MAX_SET_BITS > 7) ? 7 : MAX_SET_BITS);
    localparam logic [4:0] WY_CAP = 5'((MAX_WAYS > 15) ? 15 : MAX_WAYS);

    logic [2:0]         r_set_bits;
    logic [5:0]         r_block_bits;
    logic [3:0]         r_ways;
    slc_pkg::t_cfg      w_cfg;
    logic               w_q_ready;
    logic               w_push;
    logic [ENTRY_W-1:0] w_entry;
    logic               w_q_valid;
    logic [ENTRY_W-1:0] w_q_data;
    logic               w_pop;
    logic               w_clear_busy;

    assign o_cfg_ready = 1'b1;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= 3'd1;
            r_block_bits <= 6'd1;
            r_ways       <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                slc_pkg::CFG_SET_BITS:   r_set_bits   <= i_cfg_data[2:0];
                slc_pkg::CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                slc_pkg::CFG_WAYS:       r_ways       <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp registers to usable values
    always_comb begin
        if (r_set_bits == 3'd0) begin
            w_cfg.set_bits = 3'd1;
        end else if ({1'b0, r_set_bits} > SB_CAP) begin
            w_cfg.set_bits = SB_CAP[2:0];
        end else begin
            w_cfg.set_bits = r_set_bits;
        end
        w_cfg.block_bits = (r_block_bits == 6'd0) ? 6'd1 : r_block_bits;
        if (r_ways == 4'd0) begin
            w_cfg.ways = 4'd1;
        end else if ({1'b0, r_ways} > WY_CAP) begin
            w_cfg.ways = WY_CAP[3:0];
        end else begin
            w_cfg.ways = r_ways;
        end
    end

    slc_front #(
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_front (
        .i_valid      (i_s_tvalid),
        .i_cmd        (i_s_tuser),
        .i_addr       (i_s_tdata),
        .i_cfg        (w_cfg),
        .i_q_ready    (w_q_ready),
        .i_clear_busy (w_clear_busy),
        .o_ready      (o_s_tready),
        .o_push       (w_push),
        .o_entry      (w_entry)
    );

    slc_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_pop)
    );

    slc_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_q_valid    (w_q_valid),
        .i_q_data     (w_q_data),
        .o_pop        (w_pop),
        .o_clear_busy (w_clear_busy),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

endmodule

@@ sv/slc_queue.sv @@
module slc_queue #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign o_ready   = (r_count != CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_data    = r_data[r_rptr];
    assign w_push_ok = i_push && o_ready;
    assign w_pop_ok  = i_pop && o_valid;

    // Advance pointers and fill level
    always_comb begin
        n_wptr  = w_push_ok ? r_wptr + PTR_W'(1) : r_wptr;
        n_rptr  = w_pop_ok ? r_rptr + PTR_W'(1) : r_rptr;
        n_count = r_count + CNT_W'(w_push_ok) - CNT_W'(w_pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

@@ sv/slc_front.sv @@
module slc_front #(
    parameter int MAX_SET_BITS = 6
) (
    input  logic                              i_valid,
    input  logic [slc_pkg::CMD_W-1:0]         i_cmd,
    input  logic [slc_pkg::ADDR_W-1:0]        i_addr,
    input  slc_pkg::t_cfg                     i_cfg,
    input  logic                              i_q_ready,
    input  logic                              i_clear_busy,
    output logic                              o_ready,
    output logic                              o_push,
    output logic [MAX_SET_BITS+slc_pkg::TAG_W:0] o_entry
);

    logic [slc_pkg::ADDR_W-1:0] w_blk;
    logic [slc_pkg::ADDR_W-1:0] w_tag_full;
    logic [6:0]                 w_tshift;
    logic [MAX_SET_BITS-1:0]    w_mask;
    logic [MAX_SET_BITS-1:0]    w_set;
    logic [slc_pkg::TAG_W-1:0]  w_tag;
    logic                       w_extra;

    // Hold off words while the queue is full or the set memory is being cleared
    assign o_ready = i_q_ready && !i_clear_busy;
    assign o_push  = i_valid && o_ready;

    // Split the address into set index and tag
    always_comb begin
        w_blk    = i_addr >> i_cfg.block_bits;
        w_tshift = 7'(i_cfg.set_bits) + 7'(i_cfg.block_bits);
        w_tag_full = i_addr >> w_tshift;
        for (int i = 0; i < MAX_SET_BITS; i++) begin
            w_mask[i] = (i < int'(i_cfg.set_bits));
        end
        w_set   = w_blk[MAX_SET_BITS-1:0] & w_mask;
        w_tag   = (w_tshift >= 7'd64) ? '0 : w_tag_full[slc_pkg::TAG_W-1:0];
        w_extra = (i_cmd == slc_pkg::CMD_MODIFY);
    end

    assign o_entry = {w_extra, w_set, w_tag};

endmodule

@@ sv/slc_back.sv @@
`include "set_assoc_lru_cache_model_defines.svh"

module slc_back #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  slc_pkg::t_cfg                        i_cfg,
    input  logic                                 i_q_valid,
    input  logic [MAX_SET_BITS+slc_pkg::TAG_W:0] i_q_data,
    output logic                                 o_pop,
    output logic                                 o_clear_busy,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [slc_pkg::OUT_W-1:0]            o_m_tdata
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TREE_N   = 1 << $clog2(MAX_WAYS);
    localparam int TAG_W    = slc_pkg::TAG_W;
    localparam int STAMP_W  = slc_pkg::STAMP_W;
    localparam int CNT_W    = slc_pkg::CNT_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    // Set memory: one row per set, all ways side by side
    logic [MAX_WAYS-1:0]               mem_valid [NUM_SETS];
    logic [MAX_WAYS-1:0][TAG_W-1:0]    mem_tag   [NUM_SETS];
    logic [MAX_WAYS-1:0][STAMP_W-1:0]  mem_stamp [NUM_SETS];

    logic [MAX_WAYS-1:0]               r_rd_valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]    r_rd_tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]  r_rd_stamp;

    logic [1:0]              r_state, n_state;
    logic [MAX_SET_BITS-1:0] r_clr_cnt;
    logic [MAX_SET_BITS-1:0] r_set;
    logic [TAG_W-1:0]        r_tag;
    logic                    r_extra;
    logic [STAMP_W-1:0]      r_now;
    logic [CNT_W-1:0]        r_hits, n_hits;
    logic [CNT_W-1:0]        r_misses, n_misses;
    logic [CNT_W-1:0]        r_evicts, n_evicts;
    logic                    r_out_valid;
    logic [slc_pkg::OUT_W-1:0] r_out_data;
    logic [slc_pkg::OUT_W-1:0] w_out_word;

    // Lookup results held between compare and write back
    logic                              r_hit, n_hit;
    logic [WAY_W-1:0]                  r_hit_way, n_hit_way;
    logic                              r_free, n_free;
    logic [WAY_W-1:0]                  r_free_way, n_free_way;
    logic [MAX_WAYS-1:0]               r_inuse, w_inuse;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]  r_age, n_age;

    // Oldest-way search tree, node 1 is the root
    logic                 tr_ok  [2*TREE_N];
    logic [STAMP_W-1:0]   tr_age [2*TREE_N];
    logic [WAY_W-1:0]     tr_idx [2*TREE_N];

    logic                              w_rd_en;
    logic [MAX_SET_BITS-1:0]           w_rd_addr;
    logic                              w_wr_en;
    logic [MAX_SET_BITS-1:0]           w_wr_addr;
    logic [MAX_WAYS-1:0]               w_wr_valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]    w_wr_tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]  w_wr_stamp;
    logic [WAY_W-1:0]                  w_way;
    logic                              w_evict;
    logic                              w_out_free;
    logic                              w_done;

    assign o_clear_busy = (r_state == ST_CLEAR);
    assign o_pop        = (r_state == ST_IDLE) && i_q_valid;
    assign w_rd_en      = o_pop;
    assign w_rd_addr    = i_q_data[TAG_W +: MAX_SET_BITS];
    assign w_out_free   = !r_out_valid || i_m_tready;
    assign w_done       = (r_state == ST_WRITE) && w_out_free;
    assign w_evict      = !r_hit && !r_free;
    assign w_way        = r_hit ? r_hit_way : (r_free ? r_free_way : tr_idx[1]);

    // Compare tags and age the ways of the fetched row
    always_comb begin
        n_hit      = 1'b0;
        n_hit_way  = '0;
        n_free     = 1'b0;
        n_free_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            w_inuse[i] = (i < int'(i_cfg.ways));
            if (w_inuse[i] && r_rd_valid[i] && (r_rd_tag[i] == r_tag)) begin
                n_hit     = 1'b1;
                n_hit_way = WAY_W'(i);
            end
            if (w_inuse[i] && !r_rd_valid[i]) begin
                n_free     = 1'b1;
                n_free_way = WAY_W'(i);
            end
            n_age[i] = r_now - r_rd_stamp[i];
        end
    end

    // Pick the oldest way in use; the lower index wins a tie
    always_comb begin
        for (int n = 0; n < 2 * TREE_N; n++) begin
            tr_ok[n]  = 1'b0;
            tr_age[n] = '0;
            tr_idx[n] = '0;
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            tr_ok[TREE_N + i]  = r_inuse[i];
            tr_age[TREE_N + i] = r_age[i];
            tr_idx[TREE_N + i] = WAY_W'(i);
        end
        for (int n = TREE_N - 1; n >= 1; n--) begin
            if (tr_ok[2*n+1] && (!tr_ok[2*n] || (tr_age[2*n+1] > tr_age[2*n]))) begin
                tr_ok[n]  = 1'b1;
                tr_age[n] = tr_age[2*n+1];
                tr_idx[n] = tr_idx[2*n+1];
            end else begin
                tr_ok[n]  = tr_ok[2*n];
                tr_age[n] = tr_age[2*n];
                tr_idx[n] = tr_idx[2*n];
            end
        end
    end

    // Build the row to write back, or a cleared row during the sweep
    always_comb begin
        w_wr_en    = (r_state == ST_CLEAR) || w_done;
        w_wr_addr  = (r_state == ST_CLEAR) ? r_clr_cnt : r_set;
        w_wr_tag   = r_rd_tag;
        w_wr_stamp = r_rd_stamp;
        w_wr_tag[w_way]   = r_tag;
        w_wr_stamp[w_way] = r_now;
        if (r_state == ST_CLEAR) begin
            w_wr_valid = '0;
        end else begin
            w_wr_valid = r_rd_valid | (MAX_WAYS'(1) << w_way);
        end
    end

    // Update the running totals
    always_comb begin
        n_hits   = r_hits + CNT_W'(r_hit) + CNT_W'(r_extra);
        n_misses = r_misses + CNT_W'(!r_hit);
        n_evicts = r_evicts + CNT_W'(w_evict);
    end

    // Pack the result word, padding bits zero
    always_comb begin
        w_out_word = '0;
        w_out_word[slc_pkg::OUT_HIT_BIT]           = r_hit;
        w_out_word[slc_pkg::OUT_EVICT_BIT]         = w_evict;
        w_out_word[slc_pkg::OUT_EXTRA_BIT]         = r_extra;
        w_out_word[slc_pkg::OUT_HITS_LO +: CNT_W]  = n_hits;
        w_out_word[slc_pkg::OUT_MISS_LO +: CNT_W]  = n_misses;
        w_out_word[slc_pkg::OUT_EVICT_LO +: CNT_W] = n_evicts;
    end

    // Sequence the clear sweep after reset, then each access: fetch row, compare, write back
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_now       <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + MAX_SET_BITS'(1);
            end
            if (w_done) begin
                r_now       <= r_now + STAMP_W'(1);
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_evicts    <= n_evicts;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tag   <= i_q_data[TAG_W-1:0];
            r_set   <= w_rd_addr;
            r_extra <= i_q_data[TAG_W + MAX_SET_BITS];
        end
        if (r_state == ST_EVAL) begin
            r_hit      <= n_hit;
            r_hit_way  <= n_hit_way;
            r_free     <= n_free;
            r_free_way <= n_free_way;
            r_inuse    <= w_inuse;
            r_age      <= n_age;
        end
        if (w_done) begin
            r_out_data <= w_out_word;
        end
    end

    // Set memory ports
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_valid[w_wr_addr] <= w_wr_valid;
            mem_tag[w_wr_addr]   <= w_wr_tag;
            mem_stamp[w_wr_addr] <= w_wr_stamp;
        end
        if (w_rd_en) begin
            r_rd_valid <= mem_valid[w_rd_addr];
            r_rd_tag   <= mem_tag[w_rd_addr];
            r_rd_stamp <= mem_stamp[w_rd_addr];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `SLC_ASSERT_RST(a_rst_clear, !i_rst_n |=> o_clear_busy && !o_m_tvalid, "no clear after reset")
    `SLC_ASSERT(a_no_pop_in_clear, o_clear_busy |-> !o_pop, "queue popped during clearing pass")
    `SLC_ASSERT(a_stamp_step, w_done |=> (r_now == $past(r_now) + STAMP_W'(1)), "stamp skipped")
    `SLC_ASSERT(a_hit_valid, w_done && r_hit |-> r_rd_valid[r_hit_way], "hit on an invalid way")
    `SLC_ASSERT(a_out_from_write, $rose(o_m_tvalid) |-> $past(w_done), "stray result")

endmodule

@@ tb/tb_set_assoc_lru_cache_model.sv @@
`timescale 1ns / 100ps

module tb_set_assoc_lru_cache_model;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int NUM_LINES    = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 110;
    localparam int REPORT_LINES = 40;

    // Access kinds not named in the package
    localparam logic [slc_pkg::CMD_W-1:0] CMD_LOAD     = 2'd0;
    localparam logic [slc_pkg::CMD_W-1:0] CMD_STORE    = 2'd1;
    localparam logic [slc_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct {
        bit        hit;
        bit        evict;
        bit        extra;
        bit [31:0] hits;
        bit [31:0] misses;
        bit [31:0] evictions;
    } t_access_outcome;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic [slc_pkg::CFG_IDX_W-1:0]  i_cfg_index = slc_pkg::CFG_SET_BITS;
    logic [slc_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           i_s_tvalid  = 1'b0;
    logic [slc_pkg::ADDR_W-1:0]     i_s_tdata   = '0;
    logic [slc_pkg::CMD_W-1:0]      i_s_tuser   = CMD_LOAD;
    logic                           i_m_tready  = 1'b0;
    logic                           o_cfg_ready;
    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic [slc_pkg::OUT_W-1:0]      o_m_tdata;

    set_assoc_lru_cache_model #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Shadow copy of the cache: line arrays, stamp counter and running totals
    bit          cache_valid [NUM_LINES];
    bit [61:0]   cache_tag   [NUM_LINES];
    bit [31:0]   cache_stamp [NUM_LINES];
    bit [31:0]   stamp_now;
    bit [31:0]   hit_count;
    bit [31:0]   miss_count;
    bit [31:0]   evict_count;
    bit [2:0]    cfg_set_bits   = 3'd1;
    bit [5:0]    cfg_block_bits = 6'd1;
    bit [3:0]    cfg_ways       = 4'd1;

    t_access_outcome pending_outcomes[$];
    int unsigned     mismatch_count;
    int unsigned     results_seen;
    int unsigned     cycle_count;
    int unsigned     ready_wait;
    bit              gaps_on   = 1'b1;
    bit              jitter_on = 1'b1;
    bit              hold_active = 1'b0;
    event            hold_start;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned eff_set_bits();
        if (cfg_set_bits == 0) return 1;
        if (cfg_set_bits > MAX_SET_BITS) return MAX_SET_BITS;
        return cfg_set_bits;
    endfunction

    function automatic int unsigned eff_block_bits();
        return (cfg_block_bits == 0) ? 1 : cfg_block_bits;
    endfunction

    function automatic int unsigned eff_ways();
        if (cfg_ways == 0) return 1;
        if (cfg_ways > MAX_WAYS) return MAX_WAYS;
        return cfg_ways;
    endfunction

    // Look up one access in the shadow cache, update it, and return the outcome
    function automatic t_access_outcome cache_lookup(input logic [1:0] cmd,
                                                     input logic [63:0] addr);
        int unsigned     sb;
        int unsigned     bb;
        int unsigned     tshift;
        int unsigned     ways;
        int unsigned     base;
        int unsigned     victim;
        int unsigned     w;
        bit [63:0]       set_idx;
        bit [61:0]       tag;
        bit [31:0]       age;
        bit [31:0]       best_age;
        bit              filled;
        t_access_outcome r;
        sb      = eff_set_bits();
        bb      = eff_block_bits();
        ways    = eff_ways();
        tshift  = sb + bb;
        set_idx = (addr >> bb) & ((64'd1 << sb) - 64'd1);
        tag     = (tshift >= 64) ? 62'd0 : 62'(addr >> tshift);
        base    = int'(set_idx) * MAX_WAYS;
        r.hit   = 1'b0;
        r.evict = 1'b0;
        r.extra = (cmd == slc_pkg::CMD_MODIFY);
        filled  = 1'b0;
        // search the valid ways in use
        for (w = 0; w < ways; w++) begin
            if (cache_valid[base + w] && cache_tag[base + w] == tag) begin
                cache_stamp[base + w] = stamp_now;
                r.hit = 1'b1;
                break;
            end
        end
        // fill the lowest free way
        if (!r.hit) begin
            for (w = 0; w < ways; w++) begin
                if (!cache_valid[base + w]) begin
                    cache_valid[base + w] = 1'b1;
                    cache_tag[base + w]   = tag;
                    cache_stamp[base + w] = stamp_now;
                    filled = 1'b1;
                    break;
                end
            end
        end
        // replace the oldest way, lowest index on ties
        if (!r.hit && !filled) begin
            victim   = 0;
            best_age = stamp_now - cache_stamp[base];
            for (w = 1; w < ways; w++) begin
                age = stamp_now - cache_stamp[base + w];
                if (age > best_age) begin
                    best_age = age;
                    victim   = w;
                end
            end
            cache_tag[base + victim]   = tag;
            cache_stamp[base + victim] = stamp_now;
            r.evict = 1'b1;
        end
        stamp_now   = stamp_now + 1;
        hit_count   = hit_count + r.hit + r.extra;
        miss_count  = miss_count + !r.hit;
        evict_count = evict_count + r.evict;
        r.hits      = hit_count;
        r.misses    = miss_count;
        r.evictions = evict_count;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LINES)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Compare one result word with the oldest pending outcome
    task automatic check_result(input logic [slc_pkg::OUT_W-1:0] word);
        t_access_outcome want;
        results_seen++;
        if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no access pending",
                                      results_seen));
            return;
        end
        want = pending_outcomes.pop_front();
        if (word[slc_pkg::OUT_HIT_BIT] !== want.hit)
            report_mismatch($sformatf("result %0d was_hit got %b want %b", results_seen,
                                      word[slc_pkg::OUT_HIT_BIT], want.hit));
        if (word[slc_pkg::OUT_EVICT_BIT] !== want.evict)
            report_mismatch($sformatf("result %0d was_eviction got %b want %b", results_seen,
                                      word[slc_pkg::OUT_EVICT_BIT], want.evict));
        if (word[slc_pkg::OUT_EXTRA_BIT] !== want.extra)
            report_mismatch($sformatf("result %0d extra_hit got %b want %b", results_seen,
                                      word[slc_pkg::OUT_EXTRA_BIT], want.extra));
        if (word[slc_pkg::OUT_HITS_LO +: slc_pkg::CNT_W] !== want.hits)
            report_mismatch($sformatf("result %0d hit_total got %0d want %0d", results_seen,
                                      word[slc_pkg::OUT_HITS_LO +: slc_pkg::CNT_W], want.hits));
        if (word[slc_pkg::OUT_MISS_LO +: slc_pkg::CNT_W] !== want.misses)
            report_mismatch($sformatf("result %0d miss_total got %0d want %0d", results_seen,
                                      word[slc_pkg::OUT_MISS_LO +: slc_pkg::CNT_W],
                                      want.misses));
        if (word[slc_pkg::OUT_EVICT_LO +: slc_pkg::CNT_W] !== want.evictions)
            report_mismatch($sformatf("result %0d eviction_total got %0d want %0d",
                                      results_seen,
                                      word[slc_pkg::OUT_EVICT_LO +: slc_pkg::CNT_W],
                                      want.evictions));
        if (word[slc_pkg::OUT_W-1:slc_pkg::OUT_USED_W] !== '0)
            report_mismatch($sformatf("result %0d padding bits not zero", results_seen));
    endtask

    // Check every result word taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            check_result(o_m_tdata);
    end

    // Drive result ready: random stall bursts, or a long hold
    always @(posedge i_clk) begin
        if (hold_active) begin
            i_m_tready <= 1'b0;
        end else if (ready_wait != 0) begin
            i_m_tready <= 1'b0;
            ready_wait <= ready_wait - 1;
        end else if (jitter_on && $urandom_range(0, 7) == 0) begin
            i_m_tready <= 1'b0;
            ready_wait <= $urandom_range(0, 16);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Hold the result side off for a long stretch on request
    initial begin
        forever begin
            @(hold_start);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    // End the run if it hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Offer one access word and wait until it is taken; tvalid stays high afterwards
    task automatic send_access(input logic [1:0] cmd, input logic [63:0] addr);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= addr;
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        pending_outcomes.push_back(cache_lookup(cmd, addr));
    endtask

    // Drop tvalid and wait until every pending result has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Write one register and update the shadow copy; cfg valid stays high afterwards
    task automatic put_reg(input logic [slc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [slc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            slc_pkg::CFG_SET_BITS:   cfg_set_bits   = data[2:0];
            slc_pkg::CFG_BLOCK_BITS: cfg_block_bits = data[5:0];
            slc_pkg::CFG_WAYS:       cfg_ways       = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [2:0] sb, input logic [5:0] bb,
                              input logic [3:0] ways);
        drain_results();
        put_reg(slc_pkg::CFG_SET_BITS,   {3'd0, sb});
        put_reg(slc_pkg::CFG_BLOCK_BITS, bb);
        put_reg(slc_pkg::CFG_WAYS,       {2'd0, ways});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        set_config(3'($urandom_range(0, 7)),
                   6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 12)),
                   4'($urandom_range(0, 15)));
    endtask

    // Mostly accesses to a few tags in a few sets so lines hit and get evicted,
    // the rest fully random addresses
    task automatic random_access(input bit [61:0] tag_base, input int unsigned set_base);
        bit [63:0]   addr;
        bit [61:0]   tag;
        int unsigned set_idx;
        int unsigned tshift;
        int unsigned roll;
        logic [1:0]  cmd;
        if ($urandom_range(0, 99) < 15) begin
            addr = {$urandom, $urandom};
        end else begin
            tag     = tag_base + $urandom_range(0, eff_ways() + 2);
            set_idx = (set_base + $urandom_range(0, 3)) & ((1 << eff_set_bits()) - 1);
            tshift  = eff_set_bits() + eff_block_bits();
            addr    = {$urandom, $urandom} & ((64'd1 << eff_block_bits()) - 64'd1);
            addr    = addr | (64'(set_idx) << eff_block_bits());
            if (tshift < 64)
                addr = addr | ({2'b00, tag} << tshift);
        end
        roll = $urandom_range(0, 9);
        if (roll < 3)      cmd = CMD_LOAD;
        else if (roll < 6) cmd = CMD_STORE;
        else if (roll < 9) cmd = slc_pkg::CMD_MODIFY;
        else               cmd = CMD_RESERVED;
        send_access(cmd, addr);
    endtask

    task automatic random_phase(input int unsigned count);
        bit [61:0]   tag_base;
        int unsigned set_base;
        tag_base = 62'({$urandom, $urandom});
        set_base = $urandom;
        repeat (count) random_access(tag_base, set_base);
    endtask

    // Corner accesses: reset split, zero and saturated registers, full tag shift,
    // every access kind, LRU order through a full set
    task automatic test_directed_corners();
        int unsigned k;
        // reset split: one set bit, one offset bit, one way
        send_access(CMD_LOAD,            64'h0);
        send_access(CMD_LOAD,            64'h0);
        send_access(CMD_STORE,           64'hFFFF_FFFF_FFFF_FFFF);
        send_access(slc_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(CMD_RESERVED,        64'h1);
        send_access(CMD_LOAD,            64'h8);
        // zero register values act as one
        set_config(3'd0, 6'd0, 4'd0);
        send_access(CMD_STORE,           64'h8);
        send_access(CMD_LOAD,            64'h4);
        // set bits and ways saturate, tag shifted out completely
        set_config(3'd7, 6'd63, 4'd15);
        send_access(CMD_LOAD,            64'h0);
        send_access(CMD_STORE,           64'h8000_0000_0000_0000);
        send_access(slc_pkg::CMD_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(CMD_LOAD,            64'h7FFF_FFFF_FFFF_FFFF);
        // nine tags through one set of eight ways, then refresh and replace in LRU order
        set_config(3'd2, 6'd1, 4'd9);
        for (k = 0; k < 9; k++)
            send_access(CMD_LOAD, 64'(k) << 3);
        send_access(CMD_STORE,           64'h8);
        send_access(slc_pkg::CMD_MODIFY, 64'h0);
        send_access(CMD_LOAD,            64'h10);
    endtask

    // Random accesses under several register settings, stored lines kept across changes
    task automatic test_random_configs();
        repeat (4) begin
            random_config();
            random_phase(PHASE_ITEMS);
        end
    endtask

    // Long result stall while accesses keep coming, then a full pause
    task automatic test_backpressure();
        set_config(3'd1, 6'd2, 4'd2);
        gaps_on = 1'b0;
        -> hold_start;
        random_phase(16);
        drain_results();
        gaps_on = 1'b1;
        random_phase(40);
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_no_idle();
        random_config();
        gaps_on   = 1'b0;
        jitter_on = 1'b0;
        random_phase(PHASE_ITEMS);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_corners();
        test_random_configs();
        test_backpressure();
        test_no_idle();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_outcomes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
